// ===== sv/sbdec_pkg.sv =====
package sbdec_pkg;

    localparam int VALUE_BITS_DEF = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } t_state;

    // Operations of the shift/add-3 unit
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_STEP,
        OP_DIGIT
    } t_op;

    // Decimal digits of 2^(bits-1): floor((bits-1)*log10(2)) + 1
    function automatic int num_digits(input int bits);
        return ((bits - 1) * 30103) / 100000 + 1;
    endfunction

endpackage

// ===== sv/sbdec_dabble.sv =====
module sbdec_dabble #(
    parameter int VALUE_BITS = sbdec_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  sbdec_pkg::t_op        i_op,
    input  logic [VALUE_BITS-1:0] i_mag,
    output logic [3:0]            o_top_digit
);

    localparam int NumDigits = sbdec_pkg::num_digits(VALUE_BITS);
    localparam int BcdBits   = 4 * NumDigits;

    logic [VALUE_BITS-1:0] r_bin;
    logic [VALUE_BITS-1:0] n_bin;
    logic [BcdBits-1:0]    r_bcd;
    logic [BcdBits-1:0]    n_bcd;
    logic [BcdBits-1:0]    adj;

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < NumDigits; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        unique case (i_op)
            sbdec_pkg::OP_LOAD: begin
                n_bin = i_mag;
                n_bcd = '0;
            end
            sbdec_pkg::OP_STEP: begin
                n_bcd = {adj[BcdBits-2:0], r_bin[VALUE_BITS-1]};
                n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
            end
            sbdec_pkg::OP_DIGIT: begin
                n_bcd = {r_bcd[BcdBits-5:0], 4'd0};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_top_digit = r_bcd[BcdBits-1 -: 4];

endmodule

// ===== sv/signed_binary_to_decimal_ascii_unit.sv =====
// Signed binary to decimal ASCII converter.
// Input channel: drive i_value and raise start; the item is taken at the
// rising edge where start is high and busy is low. busy stays high until
// the last character of that item has been produced.
// Output channel: one ASCII character per o_strobe pulse on o_text_char,
// most significant first: a '-' for negative values, then the digits with
// no leading zeros (zero gives a single '0'). o_last marks the final one.
// Results are shown for exactly one cycle; the receiver cannot stall them.
// Timing: a shared shift/add-3 unit runs VALUE_BITS double-dabble steps,
// one bit per cycle, then the BCD word is shifted out one digit a cycle
// over all NumDigits positions (leading zeros are dropped silently).
// A minus sign, if any, comes out before the digits; the lead digit of a
// shorter value appears later than that of a full-width value. No new
// item is taken while busy is high; the next item can be accepted once
// busy falls, so items are converted one at a time.
// Reset (i_rst_n low, synchronous) drops any item in flight and returns the
// sequencer to idle with no strobe pending. No state spans items.
module signed_binary_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = sbdec_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic [7:0]                   o_text_char,
    output logic                         o_last,
    output logic                         o_strobe
);

    localparam int NumDigits = sbdec_pkg::num_digits(VALUE_BITS);
    localparam int CntW      = $clog2(VALUE_BITS + 1);
    localparam int DigW      = $clog2(NumDigits + 1);

    sbdec_pkg::t_state     r_state;
    sbdec_pkg::t_state     n_state;
    sbdec_pkg::t_op        op;
    logic [CntW-1:0]       r_cnt;
    logic [CntW-1:0]       n_cnt;
    logic [DigW-1:0]       r_dig;
    logic [DigW-1:0]       n_dig;
    logic                  r_neg;
    logic                  n_neg;
    logic                  r_seen;
    logic                  n_seen;
    logic                  r_strobe;
    logic                  n_strobe;
    logic [7:0]            r_char;
    logic [7:0]            n_char;
    logic                  r_last;
    logic                  n_last;
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            top_digit;

    // Magnitude of the input; the most negative value wraps to 2^(N-1)
    always_comb begin
        if (i_value[VALUE_BITS-1]) begin
            mag = ~$unsigned(i_value) + 1'b1;
        end else begin
            mag = $unsigned(i_value);
        end
    end

    sbdec_dabble #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dabble (
        .i_clk       (i_clk),
        .i_op        (op),
        .i_mag       (mag),
        .o_top_digit (top_digit)
    );

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_dig    = r_dig;
        n_neg    = r_neg;
        n_seen   = r_seen;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = 1'b0;
        op       = sbdec_pkg::OP_HOLD;
        unique case (r_state)
            sbdec_pkg::ST_IDLE: begin
                if (start) begin
                    // Take the item: load magnitude, remember sign
                    op      = sbdec_pkg::OP_LOAD;
                    n_neg   = i_value[VALUE_BITS-1];
                    n_cnt   = CntW'(VALUE_BITS);
                    n_state = sbdec_pkg::ST_CONV;
                end
            end
            sbdec_pkg::ST_CONV: begin
                // One double-dabble step per cycle
                op    = sbdec_pkg::OP_STEP;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    n_dig   = DigW'(NumDigits);
                    n_seen  = 1'b0;
                    n_state = r_neg ? sbdec_pkg::ST_SIGN : sbdec_pkg::ST_EMIT;
                end
            end
            sbdec_pkg::ST_SIGN: begin
                n_strobe = 1'b1;
                n_char   = sbdec_pkg::CHAR_MINUS;
                n_state  = sbdec_pkg::ST_EMIT;
            end
            sbdec_pkg::ST_EMIT: begin
                // Advance one digit; drop leading zeros but keep the units digit
                op    = sbdec_pkg::OP_DIGIT;
                n_dig = r_dig - 1'b1;
                if (top_digit != 4'd0 || r_seen || r_dig == DigW'(1)) begin
                    n_strobe = 1'b1;
                    n_seen   = 1'b1;
                    n_char   = sbdec_pkg::CHAR_ZERO | {4'd0, top_digit};
                    n_last   = (r_dig == DigW'(1));
                end
                if (r_dig == DigW'(1)) begin
                    n_state = sbdec_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sbdec_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sbdec_pkg::ST_IDLE;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_dig  <= n_dig;
        r_neg  <= n_neg;
        r_seen <= n_seen;
        r_char <= n_char;
    end

    assign busy        = (r_state != sbdec_pkg::ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_text_char = r_char;
    assign o_last      = r_last;

`ifndef SYNTHESIS
    a_accept_to_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == sbdec_pkg::ST_CONV))
        else $error("accepted item did not start conversion");

    a_strobe_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state != sbdec_pkg::ST_IDLE))
        else $error("character strobed without an item in flight");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("character strobed after the last one of an item");

    a_last_with_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (o_strobe && o_text_char != sbdec_pkg::CHAR_MINUS))
        else $error("last flag without a digit strobe");
`endif

endmodule
